### rtl/tkw_pkg.sv
// ----------------------------------------------------------------------------
// tkw_pkg
// Shared types, constants and ordering function for the top-K weight keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package tkw_pkg;

  localparam int ID_W                = 32;
  localparam int WEIGHT_W            = 32;
  localparam int CAP_W               = 5;
  localparam int CMD_W               = 2;
  localparam int DEFAULT_MAX_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_READOUT = 2'd2
  } cmd_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic        [ID_W-1:0]     id;
  } entry_t;

  // a orders strictly below b: by signed weight, then by id
  function automatic logic lower(entry_t a, entry_t b);
    logic res;
    if (a.weight != b.weight) begin
      res = (a.weight < b.weight);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/top_k_weight_keeper.sv
// ----------------------------------------------------------------------------
// top_k_weight_keeper
// Keeps the highest-weighted offered items, sorted, and reads them out.
// ----------------------------------------------------------------------------
// Requests come in on the s_axis channel: tuser holds the command (offer,
// clear, readout), tdata the item id and its signed Q16.16 weight. Results
// leave on m_axis: tdata id and weight, tuser the present flag, tlast marks
// the final result of a readout run. The cfg channel writes the capacity;
// write it only while the block is idle, then clear.
// The store is kept sorted ascending in a row of registers, one comparator
// per slot, so an offer or a clear is taken every cycle while no readout runs
// and finishes in the cycle it is accepted. A readout blocks the input until
// its last result is loaded (an empty store gives one result, marked last)
// while the sorted row rotates one slot per cycle through the output register;
// the accepted readout sets the run flag, which then loads the first result.
// A stalled receiver holds the output register and the rotation.
// Reset empties the store, sets capacity to 16 and drops any readout run.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_weight_keeper #(
  parameter int MAX_ENTRIES = tkw_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // cfg_data: capacity[4:0]
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [tkw_pkg::CAP_W-1:0] cfg_data,
  // s_axis_tdata: item_id[31:0], weight[63:32]
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [63:0]               s_axis_tdata,
  // s_axis_tuser: command[1:0]
  input  wire logic [1:0]                s_axis_tuser,
  // m_axis_tdata: out_id[31:0], out_weight[63:32]
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [63:0]                    m_axis_tdata,
  // m_axis_tuser: present[0]
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  import tkw_pkg::*;

  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

  // sorted store, ascending; slots at or above entry_count hold stale data
  entry_t         entries [MAX_ENTRIES];
  entry_t         entries_next [MAX_ENTRIES];
  logic [CW-1:0]  entry_count;
  logic [CW-1:0]  entry_count_next;
  logic [CAP_W-1:0] capacity;

  logic           run_active;
  logic [CW-1:0]  rd_left;
  logic           rd_empty;

  entry_t         out_entry;
  logic           out_present;
  logic           out_last;
  logic           out_valid;

  entry_t         new_entry;
  cmd_t           cmd;
  logic           in_acc;
  logic           offer_acc;
  logic           clear_acc;
  logic           readout_acc;
  logic [CW-1:0]  eff_cap;
  logic           do_insert;
  logic           do_replace;
  logic           out_load;
  logic           rotate;

  // lt[i]: new entry orders below slot i; empty slots count as +infinity
  logic [MAX_ENTRIES:0] lt;
  entry_t               hi_ext [MAX_ENTRIES+1];
  entry_t               lo_ext [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0] lt_lo;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !run_active;

  assign new_entry.id     = s_axis_tdata[ID_W-1:0];
  assign new_entry.weight = s_axis_tdata[ID_W+WEIGHT_W-1:ID_W];
  assign cmd              = cmd_t'(s_axis_tuser);
  assign in_acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    offer_acc   = 1'b0;
    clear_acc   = 1'b0;
    readout_acc = 1'b0;
    case (cmd)
      CMD_OFFER:   offer_acc   = in_acc;
      CMD_CLEAR:   clear_acc   = in_acc;
      CMD_READOUT: readout_acc = in_acc;
      default: ;
    endcase
  end

  always_comb begin
    if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lt[i]       = (CW'(i) >= entry_count) || lower(new_entry, entries[i]);
      hi_ext[i]   = entries[i];
      lo_ext[i+1] = entries[i];
      lt_lo[i+1]  = lt[i];
    end
    lt[MAX_ENTRIES]     = 1'b1;
    hi_ext[MAX_ENTRIES] = '0;
    lo_ext[0]           = new_entry;
    lt_lo[0]            = 1'b0;
  end

  assign do_insert  = offer_acc && (eff_cap != '0) && (entry_count < eff_cap);
  assign do_replace = offer_acc && (eff_cap != '0) && (entry_count >= eff_cap) &&
                      (entry_count != '0) && (new_entry.weight > entries[0].weight);

  assign out_load = run_active && (!out_valid || m_axis_tready);
  assign rotate   = out_load && !rd_empty;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      entries_next[i] = entries[i];
      if (do_insert) begin
        // shift up from the insertion point
        if (lt[i]) begin
          entries_next[i] = lt_lo[i] ? lo_ext[i] : new_entry;
        end
      end else if (do_replace) begin
        // drop the minimum, shift down below the insertion point
        if (!lt[i+1]) begin
          entries_next[i] = hi_ext[i+1];
        end else if (!lt[i]) begin
          entries_next[i] = new_entry;
        end
      end else if (rotate) begin
        if (CW'(i) == entry_count - CW'(1)) begin
          entries_next[i] = entries[0];
        end else begin
          entries_next[i] = hi_ext[i+1];
        end
      end
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    if (clear_acc) begin
      entry_count_next = '0;
    end else if (do_insert) begin
      entry_count_next = entry_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      capacity    <= CAP_RESET;
      run_active  <= 1'b0;
      rd_left     <= '0;
      rd_empty    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (readout_acc) begin
        run_active <= 1'b1;
        rd_left    <= entry_count;
        rd_empty   <= (entry_count == '0);
      end else if (out_load) begin
        rd_left <= rd_left - CW'(1);
        if (rd_empty || rd_left == CW'(1)) begin
          run_active <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_entry   <= rd_empty ? entry_t'('0) : entries[0];
      out_present <= !rd_empty;
      out_last    <= rd_empty || (rd_left == CW'(1));
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {out_entry.weight, out_entry.id};
  assign m_axis_tuser[0] = out_present;
  assign m_axis_tlast    = out_last;

  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    CMP_W'(entry_count) <= CMP_W'(MAX_ENTRIES))
    else $error("entry count above store depth");

  a_empty_is_last : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty-store result not marked last");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    clear_acc |=> entry_count == '0)
    else $error("clear left entries");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    do_insert |=> entry_count == $past(entry_count) + CW'(1))
    else $error("insert did not grow store");

  a_replace_holds : assert property (@(posedge clk) disable iff (rst)
    do_replace |=> entry_count == $past(entry_count))
    else $error("replace changed entry count");

endmodule

`default_nettype wire

### tb/tb_top_k_weight_keeper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_weight_keeper
// Self-checking bench for the top-K weight keeper.
// ----------------------------------------------------------------------------
// Offers, clears and readouts go in on s_axis; every accepted request updates
// a copy of the kept set, and a readout queues that set sorted ascending by
// weight (ties by id). Results from m_axis are matched field by field in
// order. Capacity is rewritten between phases while nothing is in flight,
// including zero, saturating values and a drop with entries still held.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] id;
  logic [31:0] weight;
  logic        present;
  logic        last;
} readout_t;

class topk_tracker;
  localparam int SLOTS = tkw_pkg::DEFAULT_MAX_ENTRIES;

  logic [31:0] slot_id [SLOTS];
  logic [31:0] slot_wt [SLOTS];
  int unsigned held;
  int unsigned cap;
  int unsigned errors;
  readout_t    due[$];

  function new();
    held   = 0;
    cap    = 16;
    errors = 0;
  endfunction

  function void set_capacity(logic [4:0] v);
    cap = (v > SLOTS) ? SLOTS : v;
  endfunction

  // weight first (signed), then id
  function bit ranks_below(logic [31:0] wa, logic [31:0] ia, logic [31:0] wb,
                           logic [31:0] ib);
    if ($signed(wa) != $signed(wb)) return $signed(wa) < $signed(wb);
    return ia < ib;
  endfunction

  function void keep_offer(logic [31:0] id, logic [31:0] w);
    int unsigned m;
    if (cap == 0) return;
    if (held < cap) begin
      slot_id[held] = id;
      slot_wt[held] = w;
      held++;
      return;
    end
    // store full (or over a lowered capacity): only the minimum can go
    m = 0;
    for (int i = 1; i < held; i++)
      if (ranks_below(slot_wt[i], slot_id[i], slot_wt[m], slot_id[m])) m = i;
    if ($signed(w) > $signed(slot_wt[m])) begin
      slot_id[m] = id;
      slot_wt[m] = w;
    end
  endfunction

  function void queue_readout();
    logic [31:0] sid [SLOTS];
    logic [31:0] swt [SLOTS];
    readout_t r;
    int j;
    if (held == 0) begin
      r.id      = '0;
      r.weight  = '0;
      r.present = 1'b0;
      r.last    = 1'b1;
      due.push_back(r);
      return;
    end
    for (int i = 0; i < held; i++) begin
      j = i;
      while (j > 0 && ranks_below(slot_wt[i], slot_id[i], swt[j-1], sid[j-1])) begin
        swt[j] = swt[j-1];
        sid[j] = sid[j-1];
        j--;
      end
      swt[j] = slot_wt[i];
      sid[j] = slot_id[i];
    end
    for (int i = 0; i < held; i++) begin
      r.id      = sid[i];
      r.weight  = swt[i];
      r.present = 1'b1;
      r.last    = (i == held - 1);
      due.push_back(r);
    end
  endfunction

  function void take_request(logic [1:0] cmd, logic [31:0] id, logic [31:0] w);
    case (cmd)
      tkw_pkg::CMD_OFFER:   keep_offer(id, w);
      tkw_pkg::CMD_CLEAR:   held = 0;
      tkw_pkg::CMD_READOUT: queue_readout();
      default: ;
    endcase
  endfunction

  function void match_result(logic [63:0] data, logic present, logic last);
    readout_t want;
    if (due.size() == 0) begin
      $error("unexpected result: out_id %h out_weight %h", data[31:0], data[63:32]);
      errors++;
      return;
    end
    want = due.pop_front();
    if (data[31:0] !== want.id) begin
      $error("out_id: expected %h, got %h", want.id, data[31:0]);
      errors++;
    end
    if (data[63:32] !== want.weight) begin
      $error("out_weight: expected %0d, got %0d", $signed(want.weight),
             $signed(data[63:32]));
      errors++;
    end
    if (present !== want.present) begin
      $error("present: expected %b, got %b", want.present, present);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %b, got %b", want.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top_k_weight_keeper;
  import tkw_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         LIMIT      = 200000;
  localparam int         SETTLE     = 8;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // item_id[31:0], weight[63:32]
  logic [1:0]  s_axis_tuser;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // out_id[31:0], out_weight[63:32]
  logic [0:0]  m_axis_tuser;   // present[0]
  logic        m_axis_tlast;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;
  topk_tracker tracker;

  top_k_weight_keeper uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("top_k_weight_keeper: mismatch");
      $finish;
    end
  end

  // results are checked before a new request is folded in
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.match_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] id,
                              input logic [31:0] w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, id};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_capacity(v);
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 54; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 54; end
      default: begin idle_pct = 9; stall_pct = 9; end
    endcase
  endtask

  task automatic random_request();
    int unsigned r;
    int          t;
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [31:0] w;
    r = $urandom_range(99);
    if (r < 78)      cmd = CMD_OFFER;
    else if (r < 90) cmd = CMD_READOUT;
    else if (r < 96) cmd = CMD_CLEAR;
    else             cmd = CMD_UNUSED;
    // narrow ids and weights now and then so ties actually happen
    id = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : 32'($urandom());
    case ($urandom_range(4))
      0: begin
        t = int'($urandom_range(4)) - 2;
        w = 32'(t * 65536);
      end
      1: w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: w = $urandom();
    endcase
    send_request(cmd, id, w);
  endtask

  initial begin
    logic [4:0] caps [8];
    tracker       = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cycles        = 0;
    set_pace(0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, ties, ignored code, empty readouts
    send_request(CMD_READOUT, 32'd0, 32'd0);
    send_request(CMD_OFFER, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(CMD_OFFER, 32'h0000_0000, 32'h8000_0000);
    send_request(CMD_OFFER, 32'd5, 32'd0);
    send_request(CMD_OFFER, 32'd3, 32'd0);
    send_request(CMD_OFFER, 32'h0000_1234, 32'hFFFF_FFFF);
    send_request(CMD_READOUT, 32'd0, 32'd0);
    send_request(CMD_UNUSED, 32'd1, 32'd1);
    send_request(CMD_READOUT, 32'd0, 32'd0);
    send_request(CMD_CLEAR, 32'd0, 32'd0);
    send_request(CMD_READOUT, 32'd0, 32'd0);

    // zero capacity drops offers
    write_capacity(5'd0);
    send_request(CMD_OFFER, 32'd7, 32'h0001_0000);
    send_request(CMD_OFFER, 32'd8, 32'h7FFF_FFFF);
    send_request(CMD_READOUT, 32'd0, 32'd0);

    // full store: equal weight is not enough to replace
    write_capacity(5'd2);
    send_request(CMD_CLEAR, 32'd0, 32'd0);
    send_request(CMD_OFFER, 32'd1, 32'h000A_0000);
    send_request(CMD_OFFER, 32'd2, 32'h000A_0000);
    send_request(CMD_OFFER, 32'd0, 32'h000A_0000);
    send_request(CMD_OFFER, 32'd9, 32'h000B_0000);
    send_request(CMD_READOUT, 32'd0, 32'd0);

    // capacity lowered with entries held
    write_capacity(5'd1);
    send_request(CMD_OFFER, 32'd4, 32'h000C_0000);
    send_request(CMD_OFFER, 32'd8, 32'h0005_0000);
    send_request(CMD_READOUT, 32'd0, 32'd0);

    caps = '{5'd31, 5'd16, 5'd1, 5'd0, 5'($urandom_range(2, 15)), 5'd20, 5'd3, 5'd16};
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      set_pace(p % 4);
      // phase 6 keeps the saturated store while capacity drops to 3
      if (p != 6) send_request(CMD_CLEAR, $urandom(), $urandom());
      repeat (28) random_request();
      send_request(CMD_READOUT, $urandom(), $urandom());
    end

    drain();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("top_k_weight_keeper: match");
    end else begin
      $display("top_k_weight_keeper: mismatch");
    end
    $finish;
  end

endmodule
